// File: hw/rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared types, command and status codes, and defaults for the list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 7;
    localparam int COUNT_W          = 7;

    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_HEAD   = 3'd1,
        CMD_TAIL   = 3'd2,
        CMD_AT     = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_code_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]               command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } ils_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } ils_rsp_t;

endpackage

// File: hw/rtl/ils_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/indexed_list_store_unit.sv
// ----------------------------------------------------------------------------
// Indexed list store unit
// Ordered list of signed values held in one RAM; inserts and deletes move
// the entries behind the given position one place per cycle.
// A refused or unused command answers in the cycle after the beat; a read
// passes through ST_READ; an insert or delete moves entries in ST_SHIFT,
// paced by the single RAM write port, then ST_FINISH. One command at a time.
// busy is high after a read, insert or delete beat until its result cycle.
// Reset clears the count and the control state; RAM contents are not reset.
// ----------------------------------------------------------------------------
module indexed_list_store_unit #(
    parameter int CAPACITY = ils_pkg::DEFAULT_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ils_pkg::ils_cmd_t request,
    output logic              done,
    output ils_pkg::ils_rsp_t result
);

    import ils_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CmpW = (CW > POS_W) ? CW : POS_W;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         at_reg, at_next;
    logic                  del_reg, del_next;
    logic [DATA_W-1:0]     value_reg, value_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic                  done_reg, done_next;
    ils_rsp_t              rsp_reg, rsp_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_W-1:0]     ram_rdata;

    logic [CmpW-1:0]       pos_w;
    logic [CmpW-1:0]       cnt_w;
    logic [CmpW-1:0]       ins_at_w;
    logic                  is_read;
    logic                  is_insert;
    logic                  is_delete;
    logic                  read_ok;
    logic                  ins_range;
    logic                  ins_full;
    logic                  del_ok;
    logic                  shift_more;

    assign pos_w = CmpW'(request.position);
    assign cnt_w = CmpW'(count_reg);

    always_comb
    begin
        is_read   = 1'b0;
        is_insert = 1'b0;
        is_delete = 1'b0;
        ins_at_w  = '0;
        unique case (request.command) inside
            CMD_READ:
            begin
                is_read = 1'b1;
            end
            CMD_HEAD:
            begin
                is_insert = 1'b1;
            end
            CMD_TAIL:
            begin
                is_insert = 1'b1;
                ins_at_w  = cnt_w;
            end
            CMD_AT:
            begin
                is_insert = 1'b1;
                ins_at_w  = pos_w;
            end
            CMD_DELETE:
            begin
                is_delete = 1'b1;
            end
            default:
            begin
                is_read = 1'b0;
            end
        endcase
    end

    assign read_ok   = pos_w < cnt_w;
    assign ins_range = ins_at_w > cnt_w;
    assign ins_full  = count_reg == CW'(CAPACITY);
    assign del_ok    = pos_w < cnt_w;
    assign shift_more = del_reg ? ((idx_reg + 1'b1) < count_reg) : (idx_reg > at_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (is_read && read_ok)
                    begin
                        state_next = ST_READ;
                    end
                    else if (is_insert && !ins_range && !ins_full)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else if (is_delete && del_ok)
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SHIFT:
            begin
                if (!shift_more)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        at_next        = at_reg;
        del_next       = del_reg;
        value_next     = value_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rsp_next.read_value = '0;
                    rsp_next.status     = STAT_DONE;
                    rsp_next.count      = COUNT_W'(count_reg);
                    value_next          = request.value;
                    if (is_read)
                    begin
                        if (read_ok)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(request.position);
                        end
                        else
                        begin
                            rsp_next.status = STAT_RANGE;
                            done_next       = 1'b1;
                        end
                    end
                    else if (is_insert)
                    begin
                        if (ins_range)
                        begin
                            rsp_next.status = STAT_RANGE;
                            done_next       = 1'b1;
                        end
                        else if (ins_full)
                        begin
                            rsp_next.status = STAT_FULL;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            at_next  = CW'(ins_at_w);
                            idx_next = count_reg;
                            del_next = 1'b0;
                        end
                    end
                    else if (is_delete)
                    begin
                        if (del_ok)
                        begin
                            at_next  = CW'(pos_w);
                            idx_next = CW'(pos_w);
                            del_next = 1'b1;
                        end
                        else
                        begin
                            rsp_next.status = STAT_RANGE;
                            done_next       = 1'b1;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                rsp_next.read_value = ram_rdata;
                done_next           = 1'b1;
            end
            ST_SHIFT:
            begin
                ram_we = pend_reg;
                if (shift_more)
                begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(idx_reg);
                    if (del_reg)
                    begin
                        ram_raddr = AW'(idx_reg + 1'b1);
                        idx_next  = idx_reg + 1'b1;
                    end
                    else
                    begin
                        ram_raddr = AW'(idx_reg - 1'b1);
                        idx_next  = idx_reg - 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (del_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(at_reg);
                    ram_wdata  = value_reg;
                end
                rsp_next.count = COUNT_W'(count_next);
                done_next      = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        at_reg        <= at_next;
        del_reg       <= del_next;
        value_reg     <= value_next;
        pend_addr_reg <= pend_addr_next;
        rsp_reg       <= rsp_next;
    end

    ils_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = rsp_reg;

    // The count never grows beyond the capacity of the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

    // The RAM is written only while entries move or the new value lands.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_READ) |-> !ram_we)
    else $error("RAM write outside shift or finish");

    // A move never reads the entry that is written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write collide");

    // The count changes only when an insert or delete completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_FINISH))
    else $error("count changed outside finish");

    // Every command that leaves idle ends with a result strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH || state_reg == ST_READ) |=> done)
    else $error("missing result strobe");

endmodule

// File: tb/indexed_list_store_unit_test.sv
// ----------------------------------------------------------------------------
// Indexed list store unit testbench
// Drives read, insert and delete commands through the start/busy handshake
// and checks every result beat against a shadow copy of the list. A short
// directed run covers the empty list, the field extremes, out-of-range
// positions and the unused command codes. Random traffic then alternates
// between filling and draining phases, so the list repeatedly runs empty
// and full.
// ----------------------------------------------------------------------------
module indexed_list_store_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    localparam int               CAP              = DEFAULT_CAPACITY;
    localparam int               HALF_PERIOD      = 5;
    localparam int               RESET_CYCLES     = 6;
    localparam int               RANDOM_ITEMS     = 1700;
    localparam longint           TIMEOUT_NS       = 10_000_000;
    localparam logic [2:0]       UNUSED_CMD_FIRST = 3'd5;
    localparam logic [2:0]       UNUSED_CMD_LAST  = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    ils_cmd_t request = '0;
    logic     done;
    ils_rsp_t result;

    ils_cmd_t cmd_backlog[$];
    ils_rsp_t rsp_due[$];
    logic signed [DATA_W-1:0] shadow_vals [CAP];
    int       shadow_len  = 0;
    int       n_queued    = 0;
    int       n_accepted  = 0;
    int       errors      = 0;
    int       idle_left   = 0;
    int       burst_left  = 0;

    indexed_list_store_unit #(
        .CAPACITY(CAP)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic ils_rsp_t apply_list_command(ils_cmd_t c);
        ils_rsp_t r;
        int       at;
        r.read_value = '0;
        r.status     = STAT_DONE;
        at           = c.position;
        case (c.command) inside
            CMD_READ:
            begin
                if (c.position < shadow_len)
                    r.read_value = shadow_vals[c.position];
                else
                    r.status = STAT_RANGE;
            end
            CMD_HEAD, CMD_TAIL, CMD_AT:
            begin
                if (c.command == CMD_HEAD)
                    at = 0;
                else if (c.command == CMD_TAIL)
                    at = shadow_len;
                if (at > shadow_len)
                    r.status = STAT_RANGE;
                else if (shadow_len >= CAP)
                    r.status = STAT_FULL;
                else
                begin
                    for (int i = shadow_len; i > at; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[at] = c.value;
                    shadow_len++;
                end
            end
            CMD_DELETE:
            begin
                if (at >= shadow_len)
                    r.status = STAT_RANGE;
                else
                begin
                    for (int i = at; i + 1 < shadow_len; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(shadow_len);
        return r;
    endfunction

    task automatic queue_cmd(logic [2:0] cmd, int pos, logic signed [DATA_W-1:0] val);
        ils_cmd_t c;
        c.command  = cmd;
        c.position = POS_W'(pos);
        c.value    = val;
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    task automatic flag_field(string field, longint want_v, longint got_v);
        $error("%s: expected %0d, actual %0d", field, want_v, got_v);
        errors++;
    endtask

    // Command driver: holds start until the beat, then inserts idle gaps between bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                rsp_due.push_back(apply_list_command(request));
                n_accepted++;
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    request <= cmd_backlog.pop_front();
                    start   <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                                : $urandom_range(1, 12);
                        case ($urandom_range(0, 7))
                            0, 1:    idle_left = 0;
                            7:       idle_left = $urandom_range(9, 80);
                            default: idle_left = $urandom_range(1, 8);
                        endcase
                    end
                    else
                        burst_left--;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin : monitor
        ils_rsp_t want;
        if (rst_n && done)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("result beat with no command outstanding");
                errors++;
            end
            else
            begin
                want = rsp_due.pop_front();
                if (result.read_value !== want.read_value)
                    flag_field("read_value", want.read_value, result.read_value);
                if (result.status !== want.status)
                    flag_field("status", want.status, result.status);
                if (result.count !== want.count)
                    flag_field("count", want.count, result.count);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("indexed_list_store_unit verification failed");
        $finish;
    end

    initial
    begin
        int                       roll;
        int                       ins_pct;
        int                       del_pct;
        int                       mode_left;
        bit                       filling;
        logic [2:0]               cmd;
        int                       pos;
        logic signed [DATA_W-1:0] val;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        queue_cmd(CMD_READ, 0, VAL_MAX);
        queue_cmd(CMD_DELETE, 0, '0);
        queue_cmd(CMD_AT, 1, VAL_MAX);
        queue_cmd(CMD_AT, 0, VAL_MAX);
        queue_cmd(CMD_HEAD, 127, VAL_MIN);
        queue_cmd(CMD_TAIL, 0, -1);
        queue_cmd(CMD_TAIL, 127, '0);
        queue_cmd(CMD_AT, 4, 32'sh5555_5555);
        queue_cmd(CMD_AT, 2, 32'shAAAA_AAAA);
        for (int k = 0; k <= 6; k++)
            queue_cmd(CMD_READ, k, '0);
        queue_cmd(CMD_READ, 127, -1);
        queue_cmd(CMD_AT, 127, VAL_MAX);
        queue_cmd(CMD_DELETE, 127, '0);
        for (int k = UNUSED_CMD_FIRST; k <= UNUSED_CMD_LAST; k++)
            queue_cmd(3'(k), 127, -1);
        queue_cmd(CMD_DELETE, 2, '0);
        queue_cmd(CMD_DELETE, 0, '0);
        queue_cmd(CMD_DELETE, 3, '0);

        filling   = 1'b1;
        mode_left = $urandom_range(100, 220);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            while (cmd_backlog.size() >= 2)
                @(negedge clk);
            if (mode_left == 0)
            begin
                filling   = !filling;
                mode_left = filling ? $urandom_range(100, 220) : $urandom_range(60, 160);
            end
            mode_left--;
            ins_pct = filling ? 60 : 12;
            del_pct = filling ? 10 : 58;
            roll    = $urandom_range(0, 99);
            if (roll < ins_pct)
            begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_HEAD;
                    1:       cmd = CMD_TAIL;
                    default: cmd = CMD_AT;
                endcase
            end
            else if (roll < ins_pct + 25)
                cmd = CMD_READ;
            else if (roll < ins_pct + 25 + del_pct)
                cmd = CMD_DELETE;
            else
                cmd = 3'($urandom_range(UNUSED_CMD_FIRST, UNUSED_CMD_LAST));

            if ($urandom_range(0, 3) == 0)
                pos = $urandom_range(0, 127);
            else if (cmd == CMD_AT)
                pos = $urandom_range(0, shadow_len);
            else
                pos = (shadow_len > 0) ? $urandom_range(0, shadow_len - 1) : 0;

            case ($urandom_range(0, 9))
                0:       val = VAL_MAX;
                1:       val = VAL_MIN;
                default: val = $urandom;
            endcase
            queue_cmd(cmd, pos, val);
        end

        while (n_accepted != n_queued || rsp_due.size() != 0)
            @(negedge clk);
        repeat (CAP + 8) @(posedge clk);

        if (errors == 0)
            $display("indexed_list_store_unit verification clean");
        else
            $display("indexed_list_store_unit verification failed");
        $finish;
    end

endmodule
